### hdl/plc_pkg.sv
// Package: shared request codes, status codes and cell control type.
`timescale 1ns / 1ps
package plc_pkg;

  // Request codes
  localparam logic [1:0] REQ_RETRIEVE = 2'd0;
  localparam logic [1:0] REQ_INSERT   = 2'd1;
  localparam logic [1:0] REQ_REMOVE   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fixed field widths
  localparam int POS_BITS = 7;
  localparam int OUT_CODE_BITS = 32;
  localparam int LEN_BITS = 7;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } plc_op_t;

endpackage

### hdl/plc_cell.sv
// One list slot: holds an entry and shifts toward either neighbor on command.
`timescale 1ns / 1ps
module plc_cell #(
  parameter int IDX = 0,
  parameter int IW = 6,
  parameter int CODE_BITS = 32
) (
  input  logic                 clk,
  input  plc_pkg::plc_op_t     op,
  input  logic [IW-1:0]        idx,
  input  logic [CODE_BITS-1:0] code,
  input  logic [CODE_BITS-1:0] left_q,
  input  logic [CODE_BITS-1:0] right_q,
  output logic [CODE_BITS-1:0] q,
  output logic [CODE_BITS-1:0] rd
);
  import plc_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [CODE_BITS-1:0] q_r;
  logic [CODE_BITS-1:0] q_nxt;

  // Pick the next slot value: load, take from the left, take from the right, or hold
  always_comb begin
    q_nxt = q_r;
    if (op.ins) begin
      if (MY_IDX == idx) begin
        q_nxt = code;
      end else if (MY_IDX > idx) begin
        q_nxt = left_q;
      end
    end else if (op.rem && (MY_IDX >= idx)) begin
      q_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q  = q_r;
  // Drive the read bus only when this slot is addressed
  assign rd = (MY_IDX == idx) ? q_r : '0;

endmodule

### hdl/positional_list_store_unit.sv
// Top level: ordered list of entry codes kept in a chain of shifting cells.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------------------
//  request | in_req_type, in_position, in_entry_code      | start && !busy
//  result  | out_status, out_read_code, out_list_length   | out_strobe, one cycle
//
// All cells shift in parallel at the accepting edge and the result appears on the next
// cycle with out_strobe high for exactly one cycle.
// busy stays low, so an item may be started every cycle.
// Reset (rst_n low, synchronous) empties the list; slot contents are not cleared.
// The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps
module positional_list_store_unit #(
  parameter int CAPACITY = 64,
  parameter int CODE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [plc_pkg::POS_BITS-1:0]   in_position,
  input  logic signed [31:0]             in_entry_code,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic signed [31:0]             out_read_code,
  output logic [plc_pkg::LEN_BITS-1:0]   out_list_length
);
  import plc_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          strobe_r;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic [31:0]   read_r;
  logic [31:0]   read_nxt;
  logic [LEN_BITS-1:0] len_r;

  logic          acc;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] pos_m1;
  logic          in_rng;
  logic          ins_rng;
  logic          full;
  logic [IW-1:0] idx;
  logic [CODE_BITS-1:0] code;
  logic [CODE_BITS-1:0] rd_sel;
  plc_op_t       op;

  logic [CODE_BITS-1:0] cell_q  [CAPACITY];
  logic [CODE_BITS-1:0] cell_rd [CAPACITY];

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Decode position against the current length
  assign pos_w   = WW'(in_position);
  assign cnt_w   = WW'(count_r);
  assign pos_m1  = pos_w - WW'(1);
  assign idx     = pos_m1[IW-1:0];
  assign in_rng  = (pos_w != '0) && (pos_w <= cnt_w);
  assign ins_rng = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
  assign full    = (count_r == CW'(CAPACITY));
  assign code    = CODE_BITS'(in_entry_code);

  // Collapse the one-hot read bus
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  // Work out status, shift command and next length
  always_comb begin
    status_nxt = ST_DONE;
    read_nxt   = '0;
    count_nxt  = count_r;
    op         = '0;
    unique case (in_req_type)
      REQ_RETRIEVE: begin
        if (!in_rng) begin
          status_nxt = ST_RANGE;
        end else begin
          read_nxt = 32'($signed(rd_sel));
        end
      end
      REQ_INSERT: begin
        if (!ins_rng) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op.ins    = acc;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (!in_rng) begin
          status_nxt = ST_RANGE;
        end else begin
          op.rem    = acc;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Chain of slots
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [CODE_BITS-1:0] left_q;
    logic [CODE_BITS-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end
    plc_cell #(
      .IDX       (g),
      .IW        (IW),
      .CODE_BITS (CODE_BITS)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .idx     (idx),
      .code    (code),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[g]),
      .rd      (cell_rd[g])
    );
  end

  // Control state: length and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= acc;
      if (acc) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      read_r   <= read_nxt;
      len_r    <= LEN_BITS'(count_nxt);
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_read_code   = $signed(read_r);
  assign out_list_length = len_r;

endmodule

### tb/testbench.sv
// Testbench for the positional list store: random and directed requests against a shadow list.
`timescale 1ns / 1ps
module testbench;
  import plc_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CODE_BITS = 32;
  localparam int ITEM_COUNT = 1100;
  localparam int IDLE_LIMIT = 2000;

  // Random-phase request mixes
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} req_mix_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_code;
    logic [LEN_BITS-1:0] list_length;
  } list_reply_t;

  // Shadow copy of the list plus the replies it predicts
  class list_shadow;
    logic [31:0] slots [CAPACITY];
    int unsigned count;
    int unsigned peak;
    int unsigned requests;
    int unsigned status_seen [4];
    int unsigned mismatches;
    list_reply_t pending_replies [$];

    function new();
      count = 0;
      peak = 0;
      requests = 0;
      mismatches = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      foreach (slots[k]) slots[k] = '0;
    endfunction

    // Apply one accepted request and queue its reply
    function void note_request(logic [1:0] kind, logic [POS_BITS-1:0] pos, logic [31:0] code);
      list_reply_t r;
      int p;
      int i;
      r = '0;
      p = int'(pos);
      r.status = ST_DONE;
      case (kind)
        REQ_RETRIEVE: begin
          if (p < 1 || p > count) r.status = ST_RANGE;
          else r.read_code = slots[p-1];
        end
        REQ_INSERT: begin
          if (p < 1 || p > count + 1) r.status = ST_RANGE;
          else if (count >= CAPACITY) r.status = ST_FULL;
          else begin
            for (i = count; i > p - 1; i--) slots[i] = slots[i-1];
            slots[p-1] = code;
            count++;
          end
        end
        REQ_REMOVE: begin
          if (p < 1 || p > count) r.status = ST_RANGE;
          else begin
            for (i = p - 1; i + 1 < count; i++) slots[i] = slots[i+1];
            count--;
          end
        end
        default: ;
      endcase
      r.list_length = count[LEN_BITS-1:0];
      if (count > peak) peak = count;
      requests++;
      status_seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    // Compare one reply with the oldest prediction
    function void check_reply(logic [1:0] status, logic [31:0] read_code,
                              logic [LEN_BITS-1:0] list_length);
      list_reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply: status %0d, read_code %0h, length %0d",
                 $time, status, read_code, list_length);
        mismatches++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, exp_r.status, status);
        mismatches++;
      end
      if (read_code !== exp_r.read_code) begin
        $display("%0t: read_code mismatch: expected %0h, got %0h",
                 $time, exp_r.read_code, read_code);
        mismatches++;
      end
      if (list_length !== exp_r.list_length) begin
        $display("%0t: list_length mismatch: expected %0d, got %0d",
                 $time, exp_r.list_length, list_length);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_req_type = REQ_RETRIEVE;
  logic [POS_BITS-1:0]        in_position = '0;
  logic signed [31:0]         in_entry_code = '0;
  logic                       out_strobe;
  logic [1:0]                 out_status;
  logic signed [31:0]         out_read_code;
  logic [LEN_BITS-1:0]        out_list_length;

  list_shadow shadow = new();
  int idle_cycles = 0;

  positional_list_store_unit #(
    .CAPACITY (CAPACITY),
    .CODE_BITS(CODE_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_entry_code  (in_entry_code),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_read_code  (out_read_code),
    .out_list_length(out_list_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every strobed reply
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      shadow.check_reply(out_status, out_read_code, out_list_length);
  end

  // Stop a run that has stopped moving items
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  // Present one item after a gap and hold it until accepted
  task automatic send_item(int gap, logic [1:0] kind, logic [POS_BITS-1:0] pos,
                           logic [31:0] code);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_entry_code <= code;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.note_request(kind, pos, code);
  endtask

  // Hold the sender until every predicted reply is in
  task automatic wait_for_replies();
    start <= 1'b0;
    while (shadow.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_code();
    case ($urandom_range(19, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Draw one request, mostly with a legal position for the current length
  task automatic pick_request(req_mix_t mix, output logic [1:0] kind,
                              output logic [POS_BITS-1:0] pos, output logic [31:0] code);
    int roll;
    int upper;
    roll = $urandom_range(99, 0);
    case (mix)
      MIX_FILL:  kind = (roll < 85) ? REQ_INSERT : (roll < 92) ? REQ_RETRIEVE :
                        (roll < 97) ? REQ_REMOVE : 2'd3;
      MIX_DRAIN: kind = (roll < 80) ? REQ_REMOVE : (roll < 88) ? REQ_INSERT :
                        (roll < 97) ? REQ_RETRIEVE : 2'd3;
      default:   kind = (roll < 35) ? REQ_INSERT : (roll < 65) ? REQ_REMOVE :
                        (roll < 97) ? REQ_RETRIEVE : 2'd3;
    endcase
    upper = (kind == REQ_INSERT) ? shadow.count + 1 : shadow.count;
    if (upper > 127) upper = 127;
    roll = $urandom_range(99, 0);
    if (roll < 85 && upper >= 1) begin
      if (roll < 17) pos = POS_BITS'(1);
      else if (roll < 34) pos = POS_BITS'(upper);
      else pos = POS_BITS'($urandom_range(upper, 1));
    end else begin
      pos = POS_BITS'($urandom_range(127, 0));
    end
    code = pick_code();
  endtask

  initial begin
    logic [1:0] kind;
    logic [POS_BITS-1:0] pos;
    logic [31:0] code;
    req_mix_t mix;
    int seg;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every position is out of range for retrieve and remove; insert at 0 or 2 is too
    send_item(pick_gap(), REQ_RETRIEVE, 7'd0, 32'h0);
    send_item(pick_gap(), REQ_RETRIEVE, 7'd1, 32'h1234_5678);
    send_item(pick_gap(), REQ_REMOVE, 7'd1, 32'h0);
    send_item(pick_gap(), REQ_INSERT, 7'd0, 32'h1);
    send_item(pick_gap(), REQ_INSERT, 7'd2, 32'h2);
    // Build a short list with extreme codes at head, tail and middle
    send_item(pick_gap(), REQ_INSERT, 7'd1, 32'h8000_0000);
    send_item(pick_gap(), REQ_INSERT, 7'd2, 32'h7fff_ffff);
    send_item(pick_gap(), REQ_INSERT, 7'd1, 32'hffff_ffff);
    send_item(pick_gap(), REQ_INSERT, 7'd4, 32'h0);
    send_item(pick_gap(), REQ_INSERT, 7'd3, 32'h5a5a_a5a5);
    send_item(pick_gap(), REQ_INSERT, 7'd7, 32'h3);
    send_item(0, REQ_RETRIEVE, 7'd1, 32'hffff_ffff);
    send_item(0, REQ_RETRIEVE, 7'd2, 32'h0);
    send_item(0, REQ_RETRIEVE, 7'd3, 32'h0);
    send_item(0, REQ_RETRIEVE, 7'd5, 32'h0);
    send_item(0, REQ_RETRIEVE, 7'd6, 32'h0);
    send_item(0, REQ_RETRIEVE, 7'd127, 32'h0);
    // Unused request type leaves the list alone
    send_item(pick_gap(), 2'd3, 7'd1, 32'hdead_beef);
    send_item(pick_gap(), REQ_REMOVE, 7'd3, 32'h0);
    send_item(pick_gap(), REQ_REMOVE, 7'd4, 32'h0);
    send_item(pick_gap(), REQ_REMOVE, 7'd5, 32'h0);
    send_item(pick_gap(), REQ_REMOVE, 7'd1, 32'h0);
    send_item(0, REQ_RETRIEVE, 7'd1, 32'h0);
    send_item(pick_gap(), REQ_INSERT, 7'd127, 32'h0);
    wait_for_replies();

    // Alternate fill, balanced and drain phases so the list hits full and empty
    for (seg = 0; seg < 9; seg++) begin
      case (seg % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      repeat (ITEM_COUNT / 9) begin
        pick_request(mix, kind, pos, code);
        send_item((seg == 4) ? 0 : pick_gap(), kind, pos, code);
      end
      wait_for_replies();
    end

    // Let the last reply settle
    repeat (4) @(posedge clk);

    $display("covered %0d requests: %0d done, %0d out of range, %0d list full",
             shadow.requests, shadow.status_seen[ST_DONE], shadow.status_seen[ST_RANGE],
             shadow.status_seen[ST_FULL]);
    $display("list length peaked at %0d of %0d, ended at %0d",
             shadow.peak, CAPACITY, shadow.count);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d replies never arrived", shadow.mismatches,
               shadow.pending());
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### positional_list_store_unit.f
hdl/plc_pkg.sv
hdl/plc_cell.sv
hdl/positional_list_store_unit.sv
tb/testbench.sv
